@@ sv/flk_pkg.sv @@
`default_nettype none

package flk_pkg;

    localparam int MAX_THREADS = 8;
    localparam int ID_W        = 3;
    localparam int LVL_W       = 3;
    localparam int CNT_W       = 4;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_THREADS);

    localparam logic [1:0] REQ_LOCK    = 2'd0;
    localparam logic [1:0] REQ_POLL    = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    localparam logic [1:0] ST_WAIT     = 2'd0;
    localparam logic [1:0] ST_GRANT    = 2'd1;
    localparam logic [1:0] ST_RELEASED = 2'd2;
    localparam logic [1:0] ST_REJECT   = 2'd3;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [ID_W-1:0] thread_id;
    } req_word_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [LVL_W-1:0] level_now;
    } rsp_word_t;

endpackage

`default_nettype wire

@@ sv/filter_lock_arbiter.sv @@
`default_nettype none

// Filter-lock arbiter for up to eight requesters. Each request word (lock, poll or
// release from one requester) is captured in an input register and resolved, once the
// result register is free, against the per-requester level and holding flops and the per-level
// victim flops; the answer lands in a result register. One word is taken every cycle
// unless the arbiter stalls, and its result is offered from the result register, as the whole decision
// (a parallel compare of all requester levels against the poller's level) fits
// between those two registers. The request side keeps moving while a result waits,
// and stalls only when both the input and result registers are full. thread_count is
// written through the cfg channel, which is always ready, and should only change
// while no word is in flight.
module filter_lock_arbiter (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_valid,
    output      logic                     req_ready,
    input  wire flk_pkg::req_word_t       req_word,
    output      logic                     rsp_valid,
    input  wire logic                     rsp_ready,
    output      flk_pkg::rsp_word_t       rsp_word,
    input  wire logic                     cfg_valid,
    output      logic                     cfg_ready,
    input  wire logic [flk_pkg::CNT_W-1:0] cfg_data
);

    localparam int N   = flk_pkg::MAX_THREADS;
    localparam int LW  = flk_pkg::LVL_W;
    localparam int CW  = flk_pkg::CNT_W;

    logic [CW-1:0]       thread_count_reg;
    logic [LW-1:0]       level_reg [N];
    logic [N-1:0]        hold_reg;
    logic [flk_pkg::ID_W-1:0] victim_reg [N];

    logic                s1_valid_reg;
    flk_pkg::req_word_t  s1_word_reg;
    logic                rsp_valid_reg;
    flk_pkg::rsp_word_t  rsp_word_reg;

    logic                out_free;
    logic                fire;

    logic [CW-1:0]       cnt;
    logic                in_range;
    logic [LW-1:0]       top;
    logic [LW-1:0]       lvl;
    logic [LW-1:0]       lvl_c;
    logic                active;
    logic                other;
    logic                blocked;
    logic [flk_pkg::ID_W-1:0] id;

    logic                lvl_wr;
    logic [LW-1:0]       lvl_val;
    logic                hold_wr;
    logic                hold_val;
    logic                vic_wr;
    logic [LW-1:0]       vic_idx;
    logic [1:0]          status;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign fire      = s1_valid_reg && out_free;
    assign req_ready = !s1_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    assign id       = s1_word_reg.thread_id;
    assign cnt      = (thread_count_reg > CW'(N)) ? CW'(N) : thread_count_reg;
    assign in_range = {1'b0, id} < cnt;
    assign top      = LW'(cnt - CW'(1));
    assign lvl      = level_reg[id];
    assign active   = (lvl != '0) || hold_reg[id];
    assign lvl_c    = (lvl > top) ? top : lvl;

    always_comb
    begin
        other = 1'b0;
        for (int k = 0; k < N; k++)
        begin
            if ((flk_pkg::ID_W'(k) != id) && ((level_reg[k] >= lvl_c) || hold_reg[k]))
            begin
                other = 1'b1;
            end
        end
    end

    assign blocked = other && (victim_reg[lvl_c] == id);

    always_comb
    begin
        lvl_wr   = 1'b0;
        lvl_val  = lvl;
        hold_wr  = 1'b0;
        hold_val = 1'b0;
        vic_wr   = 1'b0;
        vic_idx  = lvl_c;
        status   = flk_pkg::ST_REJECT;
        if (in_range)
        begin
            unique case (s1_word_reg.req_type)
                flk_pkg::REQ_LOCK:
                begin
                    if (!active)
                    begin
                        if (cnt == CW'(1))
                        begin
                            hold_wr  = 1'b1;
                            hold_val = 1'b1;
                            status   = flk_pkg::ST_GRANT;
                        end
                        else
                        begin
                            lvl_wr  = 1'b1;
                            lvl_val = LW'(1);
                            vic_wr  = 1'b1;
                            vic_idx = LW'(1);
                            status  = flk_pkg::ST_WAIT;
                        end
                    end
                end
                flk_pkg::REQ_POLL:
                begin
                    if (hold_reg[id])
                    begin
                        status = flk_pkg::ST_GRANT;
                    end
                    else if (lvl != '0)
                    begin
                        // clamp to the top level after the count is lowered
                        lvl_wr  = 1'b1;
                        lvl_val = lvl_c;
                        if (blocked)
                        begin
                            status = flk_pkg::ST_WAIT;
                        end
                        else if (lvl_c >= top)
                        begin
                            hold_wr  = 1'b1;
                            hold_val = 1'b1;
                            status   = flk_pkg::ST_GRANT;
                        end
                        else
                        begin
                            lvl_val = lvl_c + LW'(1);
                            vic_wr  = 1'b1;
                            vic_idx = lvl_c + LW'(1);
                            status  = flk_pkg::ST_WAIT;
                        end
                    end
                end
                flk_pkg::REQ_RELEASE:
                begin
                    if (active)
                    begin
                        lvl_wr   = 1'b1;
                        lvl_val  = '0;
                        hold_wr  = 1'b1;
                        hold_val = 1'b0;
                        status   = flk_pkg::ST_RELEASED;
                    end
                end
                default:
                begin
                    status = flk_pkg::ST_REJECT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thread_count_reg <= flk_pkg::COUNT_RESET;
            s1_valid_reg     <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            hold_reg         <= '0;
            for (int k = 0; k < N; k++)
            begin
                level_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                thread_count_reg <= cfg_data;
            end
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (out_free)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
            if (fire && lvl_wr)
            begin
                level_reg[id] <= lvl_val;
            end
            if (fire && hold_wr)
            begin
                hold_reg[id] <= hold_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_word_reg <= req_word;
        end
        if (fire)
        begin
            rsp_word_reg.status    <= status;
            rsp_word_reg.level_now <= lvl_wr ? lvl_val : lvl;
        end
        if (fire && vic_wr)
        begin
            victim_reg[vic_idx] <= id;
        end
    end

endmodule

`default_nettype wire

@@ sv/flk_checker.sv @@
`default_nettype none

module flk_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      req_valid,
    input wire logic                      req_ready,
    input wire logic                      rsp_valid,
    input wire logic                      rsp_ready,
    input wire flk_pkg::rsp_word_t        rsp_word,
    input wire logic                      cfg_valid,
    input wire logic                      cfg_ready
);

    // a stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
        else $error("result word changed while stalled");

    // request side never blocks while the result register is empty
    a_req_open: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request stalled with empty result register");

    // a release always leaves the requester on level 0
    a_release_lvl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_word.status == flk_pkg::ST_RELEASED)
            |-> (rsp_word.level_now == '0))
        else $error("release reported a non-zero level");

    // a result appears only after a word has been taken in
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready || (req_valid && req_ready), 2)
            || $past(req_valid && req_ready, 1) || $past(!req_ready, 1))
        else $error("result without an accepted request");

    // configuration is never refused
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind filter_lock_arbiter flk_checker u_flk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

@@ dv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_ready;
    flk_pkg::req_word_t            req_word = '0;
    logic                          rsp_valid;
    logic                          rsp_ready = 1'b0;
    flk_pkg::rsp_word_t            rsp_word;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [flk_pkg::CNT_W-1:0]     cfg_data = '0;

    // shadow of the arbiter state
    logic [flk_pkg::LVL_W-1:0]     climb_level [flk_pkg::MAX_THREADS];
    logic [flk_pkg::ID_W-1:0]      level_victim_id [flk_pkg::MAX_THREADS];
    logic                          holding [flk_pkg::MAX_THREADS];
    logic [flk_pkg::CNT_W-1:0]     thr_count = flk_pkg::COUNT_RESET;

    flk_pkg::rsp_word_t            owed_answers [$];
    flk_pkg::rsp_word_t            due;
    int                            faults = 0;
    int                            words_sent = 0;
    int                            grants_seen = 0;
    int                            rejects_seen = 0;
    int                            settings_used = 0;
    int                            idle_cycles = 0;
    int                            hold_left = 0;
    bit                            idling_on = 1'b0;

    filter_lock_arbiter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    initial
    begin
        for (int k = 0; k < flk_pkg::MAX_THREADS; k++)
        begin
            climb_level[k]     = '0;
            level_victim_id[k] = '0;
            holding[k]         = 1'b0;
        end
    end

    task automatic report_fault(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        faults++;
    endtask

    function automatic flk_pkg::req_word_t mk_word(logic [1:0] kind, int id);
        flk_pkg::req_word_t w;
        w.req_type  = kind;
        w.thread_id = flk_pkg::ID_W'(id);
        return w;
    endfunction

    // one arbitration step on the shadow state
    function automatic flk_pkg::rsp_word_t arbitrate(flk_pkg::req_word_t w);
        flk_pkg::rsp_word_t        r;
        logic [flk_pkg::CNT_W-1:0] eff;
        logic [flk_pkg::LVL_W-1:0] top;
        logic [flk_pkg::LVL_W-1:0] lv;
        logic                      active;
        logic                      others;
        int                        id;
        eff = (thr_count > flk_pkg::MAX_THREADS) ?
              flk_pkg::CNT_W'(flk_pkg::MAX_THREADS) : thr_count;
        id = w.thread_id;
        r.status = flk_pkg::ST_REJECT;
        if (id < eff)
        begin
            top = flk_pkg::LVL_W'(eff - 1);
            lv = climb_level[id];
            active = (lv != 0) || holding[id];
            case (w.req_type)
                flk_pkg::REQ_LOCK:
                    if (!active)
                    begin
                        if (eff == 1)
                        begin
                            holding[id] = 1'b1;
                            r.status = flk_pkg::ST_GRANT;
                        end
                        else
                        begin
                            climb_level[id] = flk_pkg::LVL_W'(1);
                            level_victim_id[1] = flk_pkg::ID_W'(id);
                            r.status = flk_pkg::ST_WAIT;
                        end
                    end
                flk_pkg::REQ_POLL:
                    if (holding[id])
                        r.status = flk_pkg::ST_GRANT;
                    else if (lv != 0)
                    begin
                        if (lv > top)
                        begin
                            lv = top;
                            climb_level[id] = lv;
                        end
                        others = 1'b0;
                        for (int k = 0; k < flk_pkg::MAX_THREADS; k++)
                            if (k != id && (climb_level[k] >= lv || holding[k]))
                                others = 1'b1;
                        if (others && level_victim_id[lv] == flk_pkg::ID_W'(id))
                            r.status = flk_pkg::ST_WAIT;
                        else if (lv >= top)
                        begin
                            holding[id] = 1'b1;
                            r.status = flk_pkg::ST_GRANT;
                        end
                        else
                        begin
                            climb_level[id] = lv + flk_pkg::LVL_W'(1);
                            level_victim_id[lv + flk_pkg::LVL_W'(1)] = flk_pkg::ID_W'(id);
                            r.status = flk_pkg::ST_WAIT;
                        end
                    end
                flk_pkg::REQ_RELEASE:
                    if (active)
                    begin
                        climb_level[id] = '0;
                        holding[id] = 1'b0;
                        r.status = flk_pkg::ST_RELEASED;
                    end
                default: ;
            endcase
        end
        r.level_now = climb_level[id];
        return r;
    endfunction

    // mostly well-formed lock/poll/release traffic, some noise
    function automatic flk_pkg::req_word_t pick_word();
        flk_pkg::req_word_t w;
        int                 eff;
        int                 id;
        eff = (thr_count > flk_pkg::MAX_THREADS) ? flk_pkg::MAX_THREADS : int'(thr_count);
        if (eff == 0 || $urandom_range(0, 9) == 0)
        begin
            w.req_type  = 2'($urandom_range(0, 3));
            w.thread_id = flk_pkg::ID_W'($urandom_range(0, flk_pkg::MAX_THREADS - 1));
        end
        else
        begin
            id = int'($urandom_range(0, eff - 1));
            w.thread_id = flk_pkg::ID_W'(id);
            if (holding[id])
                w.req_type = ($urandom_range(0, 2) == 0) ?
                             flk_pkg::REQ_POLL : flk_pkg::REQ_RELEASE;
            else if (climb_level[id] != 0)
                w.req_type = ($urandom_range(0, 7) == 0) ?
                             flk_pkg::REQ_RELEASE : flk_pkg::REQ_POLL;
            else
                w.req_type = ($urandom_range(0, 7) == 0) ?
                             2'($urandom_range(0, 3)) : flk_pkg::REQ_LOCK;
        end
        // with one requester a stranded waiter would look up the level 0 victim,
        // which is never set
        if (eff == 1 && w.thread_id == '0 && w.req_type == flk_pkg::REQ_POLL &&
            !holding[0] && climb_level[0] != '0)
            w.req_type = flk_pkg::REQ_RELEASE;
        return w;
    endfunction

    task automatic send_word(flk_pkg::req_word_t w);
        flk_pkg::rsp_word_t r;
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        do @(posedge clk); while (!req_ready);
        r = arbitrate(w);
        owed_answers.push_back(r);
        words_sent++;
        if (r.status == flk_pkg::ST_GRANT)
            grants_seen++;
        if (r.status == flk_pkg::ST_REJECT)
            rejects_seen++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (owed_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_count(logic [flk_pkg::CNT_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        thr_count = v;
        settings_used++;
    endtask

    task automatic test_basic_contention();
        idling_on = 1'b1;
        send_word(mk_word(flk_pkg::REQ_LOCK, 0));
        send_word(mk_word(flk_pkg::REQ_LOCK, 7));
        send_word(mk_word(flk_pkg::REQ_POLL, 7));
        send_word(mk_word(flk_pkg::REQ_POLL, 0));
        send_word(mk_word(flk_pkg::REQ_LOCK, 0));
        send_word(mk_word(flk_pkg::REQ_POLL, 3));
        send_word(mk_word(flk_pkg::REQ_RELEASE, 4));
        send_word(mk_word(flk_pkg::REQ_UNUSED, 5));
        send_word(mk_word(flk_pkg::REQ_RELEASE, 7));
    endtask

    task automatic test_count_changes();
        write_count(4'd15);
        write_count(4'd2);
        send_word(mk_word(flk_pkg::REQ_POLL, 0));
        send_word(mk_word(flk_pkg::REQ_POLL, 0));
        send_word(mk_word(flk_pkg::REQ_LOCK, 1));
        send_word(mk_word(flk_pkg::REQ_POLL, 1));
        send_word(mk_word(flk_pkg::REQ_LOCK, 5));
        write_count(4'd8);
        send_word(mk_word(flk_pkg::REQ_LOCK, 6));
        send_word(mk_word(flk_pkg::REQ_POLL, 1));
        send_word(mk_word(flk_pkg::REQ_RELEASE, 0));
        write_count(4'd1);
        send_word(mk_word(flk_pkg::REQ_LOCK, 0));
        send_word(mk_word(flk_pkg::REQ_POLL, 6));
        send_word(mk_word(flk_pkg::REQ_RELEASE, 0));
        write_count(4'd0);
        send_word(mk_word(flk_pkg::REQ_LOCK, 0));
        send_word(mk_word(flk_pkg::REQ_RELEASE, 1));
    endtask

    task automatic test_random_traffic();
        logic [flk_pkg::CNT_W-1:0] counts [6];
        counts = '{4'd8, 4'd3, 4'd2, 4'd1, 4'd15, flk_pkg::CNT_W'($urandom_range(4, 7))};
        for (int p = 0; p < 6; p++)
        begin
            write_count(counts[p]);
            idling_on = (p != 2);
            for (int n = 0; n < 110; n++)
            begin
                if (n == 55)
                    drain();
                send_word(pick_word());
            end
        end
    endtask

    task automatic test_calm_tail();
        write_count(4'd8);
        idling_on = 1'b0;
        for (int n = 0; n < 120; n++)
            send_word(pick_word());
    endtask

    // receiver drops rsp_ready in random bursts while idling_on is set
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            hold_left = $urandom_range(0, 4);
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (owed_answers.size() == 0)
                report_fault($sformatf("unexpected answer status=%0d level=%0d",
                                       rsp_word.status, rsp_word.level_now));
            else
            begin
                due = owed_answers.pop_front();
                if (rsp_word.status !== due.status)
                    report_fault($sformatf("status got %0d want %0d",
                                           rsp_word.status, due.status));
                if (rsp_word.level_now !== due.level_now)
                    report_fault($sformatf("level_now got %0d want %0d",
                                           rsp_word.level_now, due.level_now));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_contention();
        test_count_changes();
        test_random_traffic();
        test_calm_tail();
        drain();
        repeat (10) @(posedge clk);
        $display("Sent %0d request words over %0d thread_count writes (0, 1, 2, 3, 8, 15 and one",
                 words_sent, settings_used);
        $display("in 4..7); %0d grants and %0d rejects predicted.", grants_seen, rejects_seen);
        if (faults == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
